[sv/cba_pkg.sv]
// Shared types, field widths, codes and command/status structs for the
// contiguous block allocator. No dependencies.
package cba_pkg;

  localparam int MAX_BLOCKS_DEF = 256;

  localparam int BB_W     = 13;
  localparam int ACT_W    = 9;
  localparam int SIZE_W   = 21;
  localparam int OFS_W    = 20;
  localparam int HEAD_W   = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BLOCKS = 2'd1;

  localparam logic [BB_W-1:0]  BB_RESET  = 13'd64;
  localparam logic [BB_W-1:0]  BB_MAX    = 13'd4096;
  localparam logic [ACT_W-1:0] ACT_RESET = 9'd256;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [SIZE_W-1:0]   size_bytes;
    logic [OFS_W-1:0]    region_offset;
  } in_t;

  typedef struct packed {
    logic                ok;
    logic [OFS_W-1:0]    alloc_offset;
    logic [HEAD_W-1:0]   head_block;
  } out_t;

  typedef enum logic [1:0] {
    RES_FAIL,
    RES_OK,
    RES_ALLOC
  } res_t;

  typedef enum logic {
    DIV_SIZE,
    DIV_OFFSET
  } div_sel_t;

  typedef enum logic [1:0] {
    SWP_WIPE,
    SWP_MARK,
    SWP_FREE
  } swp_mode_t;

  typedef struct packed {
    logic      load;
    logic      div_start;
    div_sel_t  div_sel;
    logic      cap_base;
    logic      cap_cnt;
    logic      scan_init;
    logic      scan_step;
    logic      sweep_init;
    swp_mode_t sweep_mode;
    logic      sweep_run;
    logic      mult;
    logic      out_load;
    res_t      res;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    size_zero;
    logic    div_done;
    logic    need_gt_act;
    logic    found;
    logic    exhausted;
    logic    sweep_done;
  } sts_t;

endpackage

[sv/contiguous_block_allocator.sv]
// Top level of the contiguous block allocator: controller plus datapath.
// Depends on cba_pkg, cba_ctrl and cba_datapath.
//
// One request at a time; the next is taken once the current result is in the
// output register. For an allocate, the bit-serial divider converts bytes to
// blocks, the first-fit scan reads the used-map memory one block a cycle,
// and marking writes one block a cycle. A failed size check ends before the
// scan. Free runs two divisions, then one write per freed block; clear sweeps
// the whole used map and unknown actions return a failed result. After reset
// a clearing pass runs through the used map while requests are stalled;
// configuration writes are taken at any time.
module contiguous_block_allocator #(
  parameter int MAX_BLOCKS = cba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cba_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cba_pkg::out_t                  out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cba_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  cba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

[sv/cba_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Depends on cba_pkg for the dividend and divisor widths.
module cba_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cba_pkg::SIZE_W-1:0] dividend,
  input  logic [cba_pkg::BB_W-1:0]   divisor,
  output logic                       done,
  output logic [cba_pkg::SIZE_W-1:0] quotient,
  output logic                       rem_nz
);
  import cba_pkg::*;

  localparam int STEP_W = $clog2(SIZE_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SIZE_W - 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [BB_W:0]     rem_r;
  logic [SIZE_W-1:0] quo_r;

  logic [BB_W:0]     shifted;
  logic              take;
  logic [BB_W:0]     rem_next;

  // The partial remainder stays below the divisor, so its low bits hold it.
  always_comb begin
    shifted  = {rem_r[BB_W-1:0], quo_r[SIZE_W-1]};
    take     = shifted >= {1'b0, divisor};
    rem_next = take ? (shifted - {1'b0, divisor}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      if (step_r == LAST_STEP) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_next;
      quo_r <= {quo_r[SIZE_W-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
  assign rem_nz   = rem_r != '0;

endmodule

[sv/cba_datapath.sv]
// Datapath of the block allocator: configuration registers, used-map memory,
// scan and sweep counters, divider, offset multiplier and result register.
// Depends on cba_pkg and cba_div.
module cba_datapath #(
  parameter int MAX_BLOCKS = cba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [cba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cba_pkg::CFG_DATA_W-1:0] cfg_data,
  input  cba_pkg::in_t                   in_data,
  input  cba_pkg::cmd_t                  cmd,
  output cba_pkg::sts_t                  sts,
  output cba_pkg::out_t                  out_data
);
  import cba_pkg::*;

  localparam int BW  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int AW  = $clog2(MAX_BLOCKS + 1);
  localparam int CW  = (AW > ACT_W) ? AW : ACT_W;
  localparam int PW  = AW + BB_W;
  localparam int SW1 = SIZE_W + 1;
  localparam logic [AW-1:0] MAX_A = AW'(MAX_BLOCKS);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_BLOCKS);

  logic [BB_W-1:0]   bb_cfg_r;
  logic [ACT_W-1:0]  act_cfg_r;
  in_t               req_r;
  logic [SIZE_W-1:0] base_r;
  logic [SIZE_W-1:0] cnt_r;
  logic [AW-1:0]     head_r;
  logic [AW-1:0]     run_r;
  logic [AW-1:0]     rd_idx_r;
  logic [AW-1:0]     chk_idx_r;
  logic              chk_vld_r;
  logic              rd_data_r;
  logic [AW-1:0]     idx_r;
  logic [AW-1:0]     end_r;
  logic              wr_bit_r;
  logic [PW-1:0]     prod_r;
  out_t              out_r;

  logic used_mem [MAX_BLOCKS];

  logic [BB_W-1:0]   bb_eff;
  logic [AW-1:0]     act_eff;
  logic [SIZE_W-1:0] div_dividend;
  logic              div_done;
  logic [SIZE_W-1:0] quo;
  logic              rem_nz;
  logic              issue;
  logic              rd_en;
  logic              wr_en;
  logic [AW-1:0]     found_head;
  logic              found;
  logic [SIZE_W-1:0] act_s;
  logic              in_range;
  logic [SIZE_W-1:0] room;
  logic [SW1-1:0]    stop;
  logic [AW-1:0]     free_end;

  always_comb begin
    if (bb_cfg_r == '0) begin
      bb_eff = BB_W'(1);
    end else if (bb_cfg_r > BB_MAX) begin
      bb_eff = BB_MAX;
    end else begin
      bb_eff = bb_cfg_r;
    end
    if (CW'(act_cfg_r) > MAX_C) begin
      act_eff = MAX_A;
    end else begin
      act_eff = AW'(act_cfg_r);
    end
  end

  assign div_dividend = (cmd.div_sel == DIV_SIZE) ? req_r.size_bytes
                                                  : SIZE_W'(req_r.region_offset);

  cba_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (bb_eff),
    .done     (div_done),
    .quotient (quo),
    .rem_nz   (rem_nz)
  );

  // The scan reads one block a cycle; the data returns the next cycle, so
  // the read pointer runs one block ahead of the block being checked.
  always_comb begin
    issue      = rd_idx_r < act_eff;
    rd_en      = cmd.scan_step && issue;
    found_head = (run_r == '0) ? chk_idx_r : head_r;
    found      = chk_vld_r && !rd_data_r &&
                 ((SIZE_W'(run_r) + SIZE_W'(1)) == cnt_r);
    wr_en      = cmd.sweep_run && (idx_r < end_r);
  end

  // A freed run is clipped to the active blocks.
  always_comb begin
    act_s    = SIZE_W'(act_eff);
    in_range = base_r < act_s;
    room     = act_s - base_r;
    stop     = SW1'(base_r) + SW1'(cnt_r);
    free_end = (cnt_r > room) ? act_eff : AW'(stop);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      used_mem[idx_r[BW-1:0]] <= wr_bit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= used_mem[rd_idx_r[BW-1:0]];
    end
  end

  // After reset the sweep range covers the whole map, so the controller's
  // first pass clears it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bb_cfg_r  <= BB_RESET;
      act_cfg_r <= ACT_RESET;
      chk_vld_r <= 1'b0;
      idx_r     <= '0;
      end_r     <= MAX_A;
      wr_bit_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCK_BYTES:   bb_cfg_r  <= cfg_data[BB_W-1:0];
          CFG_ACTIVE_BLOCKS: act_cfg_r <= cfg_data[ACT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.scan_init) begin
        chk_vld_r <= 1'b0;
      end else if (cmd.scan_step) begin
        chk_vld_r <= issue;
      end
      if (cmd.sweep_init) begin
        case (cmd.sweep_mode)
          SWP_WIPE: begin
            idx_r    <= '0;
            end_r    <= MAX_A;
            wr_bit_r <= 1'b0;
          end
          SWP_MARK: begin
            idx_r    <= found_head;
            end_r    <= chk_idx_r + AW'(1);
            wr_bit_r <= 1'b1;
          end
          SWP_FREE: begin
            idx_r    <= in_range ? AW'(base_r) : '0;
            end_r    <= in_range ? free_end : '0;
            wr_bit_r <= 1'b0;
          end
          default: begin
            idx_r    <= '0;
            end_r    <= '0;
            wr_bit_r <= 1'b0;
          end
        endcase
      end else if (wr_en) begin
        idx_r <= idx_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.cap_base) begin
      base_r <= quo;
    end
    if (cmd.cap_cnt) begin
      cnt_r <= quo + SIZE_W'(rem_nz);
    end
    if (cmd.scan_init) begin
      rd_idx_r <= '0;
      run_r    <= '0;
      head_r   <= '0;
    end else if (cmd.scan_step) begin
      if (issue) begin
        rd_idx_r <= rd_idx_r + AW'(1);
      end
      chk_idx_r <= rd_idx_r;
      if (chk_vld_r) begin
        if (!rd_data_r) begin
          if (run_r == '0) begin
            head_r <= chk_idx_r;
          end
          run_r <= run_r + AW'(1);
        end else begin
          run_r <= '0;
        end
      end
    end
    if (cmd.sweep_init && (cmd.sweep_mode == SWP_MARK)) begin
      head_r <= found_head;
    end
    if (cmd.mult) begin
      prod_r <= PW'(head_r) * PW'(bb_eff);
    end
    if (cmd.out_load) begin
      case (cmd.res)
        RES_ALLOC: begin
          out_r.ok           <= 1'b1;
          out_r.alloc_offset <= OFS_W'(prod_r);
          out_r.head_block   <= HEAD_W'(head_r);
        end
        RES_OK: begin
          out_r.ok           <= 1'b1;
          out_r.alloc_offset <= '0;
          out_r.head_block   <= '0;
        end
        default: begin
          out_r.ok           <= 1'b0;
          out_r.alloc_offset <= '0;
          out_r.head_block   <= '0;
        end
      endcase
    end
  end

  always_comb begin
    sts.action      = req_r.action;
    sts.size_zero   = req_r.size_bytes == '0;
    sts.div_done    = div_done;
    sts.need_gt_act = cnt_r > SIZE_W'(act_eff);
    sts.found       = found;
    sts.exhausted   = !chk_vld_r && !issue;
    sts.sweep_done  = idx_r >= end_r;
  end

  assign out_data = out_r;

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step |-> !wr_en)
    else $error("used map written during a scan");

  a_run_in_active: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sweep_init && (cmd.sweep_mode != SWP_WIPE)) |=> (end_r <= $past(act_eff)))
    else $error("mark or free range passes the active blocks");

  a_read_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (rd_idx_r < MAX_A))
    else $error("scan read beyond the used map");

endmodule

[sv/cba_ctrl.sv]
// Controller state machine of the block allocator: sequences division,
// scan, map sweeps and result delivery. Depends on cba_pkg.
module cba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  cba_pkg::sts_t sts,
  output cba_pkg::cmd_t cmd
);
  import cba_pkg::*;

  typedef enum logic [3:0] {
    S_WIPE,
    S_IDLE,
    S_DISPATCH,
    S_DIV_OFS,
    S_DIV_SIZE,
    S_PLAN,
    S_SCAN,
    S_SWEEP,
    S_MULT,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  res_t   res_r, res_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    cmd.res       = res_r;
    state_nxt     = state_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_WIPE: begin
        cmd.sweep_run = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.action)
          ACT_ALLOC: begin
            if (sts.size_zero) begin
              res_nxt   = RES_FAIL;
              state_nxt = S_DONE;
            end else begin
              cmd.div_start = 1'b1;
              cmd.div_sel   = DIV_SIZE;
              state_nxt     = S_DIV_SIZE;
            end
          end
          ACT_FREE: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_OFFSET;
            state_nxt     = S_DIV_OFS;
          end
          ACT_CLEAR: begin
            cmd.sweep_init = 1'b1;
            cmd.sweep_mode = SWP_WIPE;
            res_nxt        = RES_OK;
            state_nxt      = S_SWEEP;
          end
          default: begin
            res_nxt   = RES_FAIL;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DIV_OFS: begin
        if (sts.div_done) begin
          cmd.cap_base  = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_SIZE;
          state_nxt     = S_DIV_SIZE;
        end
      end
      S_DIV_SIZE: begin
        if (sts.div_done) begin
          cmd.cap_cnt = 1'b1;
          state_nxt   = S_PLAN;
        end
      end
      S_PLAN: begin
        if (sts.action == ACT_FREE) begin
          cmd.sweep_init = 1'b1;
          cmd.sweep_mode = SWP_FREE;
          res_nxt        = RES_OK;
          state_nxt      = S_SWEEP;
        end else if (sts.need_gt_act) begin
          res_nxt   = RES_FAIL;
          state_nxt = S_DONE;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.found) begin
          cmd.sweep_init = 1'b1;
          cmd.sweep_mode = SWP_MARK;
          res_nxt        = RES_ALLOC;
          state_nxt      = S_SWEEP;
        end else if (sts.exhausted) begin
          res_nxt   = RES_FAIL;
          state_nxt = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SWEEP: begin
        cmd.sweep_run = 1'b1;
        if (sts.sweep_done) begin
          state_nxt = (res_r == RES_ALLOC) ? S_MULT : S_DONE;
        end
      end
      S_MULT: begin
        cmd.mult  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // The result register is free, or its current result leaves now.
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WIPE;
      res_r       <= RES_FAIL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  a_load_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("result loaded over one not yet taken");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken before the first finished");

  a_found_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && sts.found) |=> (state_r == S_SWEEP && res_r == RES_ALLOC))
    else $error("found run not marked");

endmodule

[dv/contiguous_block_allocator_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the contiguous block allocator: predicts each
// result from its own model of the used map. Depends on cba_pkg and the top level.
module contiguous_block_allocator_test;
  import cba_pkg::*;

  localparam int NBLK            = MAX_BLOCKS_DEF;
  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int TAIL_CYCLES     = 600;
  localparam int PRINT_LIMIT     = 50;
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [OFS_W-1:0]  ofs;
    logic [SIZE_W-1:0] size;
  } region_t;

  // Mirrors the used map and the two registers, and holds the results still owed.
  class alloc_scoreboard;
    bit [NBLK-1:0] used_map;
    int unsigned   blk_bytes;
    int unsigned   act_blocks;
    out_t          result_q[$];
    int            errors;

    function new();
      used_map   = '0;
      blk_bytes  = 32'(BB_RESET);
      act_blocks = 32'(ACT_RESET);
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_BLOCK_BYTES:   blk_bytes  = 32'(value);
        CFG_ACTIVE_BLOCKS: act_blocks = 32'(value[ACT_W-1:0]);
        default: ;
      endcase
    endfunction

    function int unsigned eff_bb();
      if (blk_bytes == 0) return 1;
      if (blk_bytes > BB_MAX) return 32'(BB_MAX);
      return blk_bytes;
    endfunction

    function int unsigned eff_act();
      return (act_blocks > NBLK) ? NBLK : act_blocks;
    endfunction

    function int unsigned to_blocks(int unsigned bytes, int unsigned bb);
      return bytes / bb + 32'((bytes % bb) != 0);
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    function out_t note_request(in_t r);
      out_t        res;
      int unsigned bb, act, need, run, head, size, last;
      res  = '0;
      bb   = eff_bb();
      act  = eff_act();
      size = 32'(r.size_bytes);
      case (r.action)
        ACT_ALLOC: begin
          need = to_blocks(size, bb);
          if (size != 0 && need <= act) begin
            run  = 0;
            head = 0;
            for (int i = 0; i < act; i++) begin
              if (!used_map[i]) begin
                if (run == 0) head = i;
                run++;
                if (run == need) break;
              end else begin
                run = 0;
              end
            end
            // A run cut short by the last active block is not a fit.
            if (run == need) begin
              for (int i = head; i < head + need; i++) used_map[i] = 1'b1;
              res.ok           = 1'b1;
              res.alloc_offset = OFS_W'(head * bb);
              res.head_block   = HEAD_W'(head);
            end
          end
        end
        ACT_FREE: begin
          head = 32'(r.region_offset) / bb;
          need = to_blocks(size, bb);
          if (head < act) begin
            last = (need > act - head) ? act : head + need;
            for (int i = head; i < last; i++) used_map[i] = 1'b0;
          end
          res.ok = 1'b1;
        end
        ACT_CLEAR: begin
          used_map = '0;
          res.ok   = 1'b1;
        end
        default: ;
      endcase
      result_q.push_back(res);
      return res;
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("%0t ERROR: %s", $realtime, msg);
    endtask

    task check_result(out_t got);
      out_t want;
      if (result_q.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: %p", got));
        return;
      end
      want = result_q.pop_front();
      if (got.ok !== want.ok)
        report_mismatch($sformatf("ok %b, expected %b", got.ok, want.ok));
      if (got.alloc_offset !== want.alloc_offset)
        report_mismatch($sformatf("alloc_offset %0d, expected %0d",
                                  got.alloc_offset, want.alloc_offset));
      if (got.head_block !== want.head_block)
        report_mismatch($sformatf("head_block %0d, expected %0d",
                                  got.head_block, want.head_block));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_t                  out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  alloc_scoreboard sb;
  region_t         live_q[$];
  int              burst_left = 0;
  bit              hold_off_req = 1'b0;
  int unsigned     cycle_count = 0;

  contiguous_block_allocator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("contiguous_block_allocator_test failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Receiver: stretches of differing stall density, plus one long hold-off on request.
  initial begin
    int unsigned span, mode;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 200);
        for (int k = 0; k < span; k++) begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ($urandom_range(0, 99) < 70);
            default: out_stall <= k[1];
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic in_t mk(action_t a, int unsigned size, int unsigned ofs);
    in_t r;
    r.action        = a;
    r.size_bytes    = SIZE_W'(size);
    r.region_offset = OFS_W'(ofs);
    return r;
  endfunction

  // Mostly allocations and frees of live regions, with some noise, clears
  // and unknown actions mixed in.
  function automatic in_t make_request();
    in_t         r;
    int unsigned bb, amax, pick, sel, k, idx, size;
    bb   = sb.eff_bb();
    amax = (sb.eff_act() == 0) ? 1 : sb.eff_act();
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        size = 0;
      end else if (sel < 95) begin
        if (sel < 63)      k = $urandom_range(1, (amax / 8 > 1) ? amax / 8 : 1);
        else if (sel < 88) k = $urandom_range(1, amax);
        else               k = amax + $urandom_range(1, 3);
        size = (k - 1) * bb + $urandom_range(1, bb);
      end else begin
        size = $urandom;
      end
      r = mk(ACT_ALLOC, size, 0);
    end else if (pick < 80 && live_q.size() > 0) begin
      idx = $urandom_range(0, live_q.size() - 1);
      r = mk(ACT_FREE, live_q[idx].size, live_q[idx].ofs + $urandom_range(0, bb - 1));
      live_q.delete(idx);
    end else if (pick < 95) begin
      r.action        = action_t'($urandom_range(0, 2));
      r.size_bytes    = $urandom_range(0, 1) ? SIZE_W'($urandom)
                                             : SIZE_W'($urandom_range(0, 8 * bb));
      r.region_offset = $urandom_range(0, 1) ? OFS_W'($urandom)
                                             : OFS_W'($urandom_range(0, amax * bb));
    end else if (pick < 98) begin
      r = mk(ACT_CLEAR, $urandom, $urandom);
    end else begin
      r = mk(action_t'(ACT_UNKNOWN), $urandom, $urandom);
    end
    return r;
  endfunction

  task automatic push_request(input in_t r);
    out_t exp_res;
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    exp_res = sb.note_request(r);
    if (r.action == ACT_ALLOC && exp_res.ok)
      live_q.push_back('{ofs: exp_res.alloc_offset, size: r.size_bytes});
    else if (r.action == ACT_CLEAR)
      live_q.delete();
  endtask

  // Requests go out in bursts; valid drops only at the start of a gap.
  task automatic offer(input in_t r);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                              : $urandom_range(1, 8);
    end
    burst_left--;
    push_request(r);
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] bb_val,
                           input logic [CFG_DATA_W-1:0] act_val,
                           input int n_items, input bit hold, input int pause_at);
    in_valid <= 1'b0;
    burst_left = 0;
    wait_drain();
    put_reg(CFG_BLOCK_BYTES, bb_val);
    put_reg(CFG_ACTIVE_BLOCKS, act_val);
    cfg_valid <= 1'b0;
    offer(mk(ACT_CLEAR, 0, 0));
    if (hold) hold_off_req = 1'b1;
    for (int k = 0; k < n_items; k++) begin
      if (k == pause_at) begin
        in_valid <= 1'b0;
        burst_left = 0;
        wait_drain();
      end
      offer(make_request());
    end
  endtask

  initial begin
    in_t dir_q[$];
    sb = new();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: 64-byte blocks, all 256 managed.
    dir_q.push_back(mk(ACT_ALLOC, 0, 0));
    dir_q.push_back(mk(ACT_ALLOC, 1, 0));
    dir_q.push_back(mk(ACT_ALLOC, 64, 0));
    dir_q.push_back(mk(ACT_ALLOC, 65, 0));
    dir_q.push_back(mk(ACT_FREE, 64, 64));
    dir_q.push_back(mk(ACT_ALLOC, 64, 0));
    dir_q.push_back(mk(ACT_ALLOC, 21'h1FFFFF, 20'hFFFFF));
    // A full-map request with the head blocks taken: the tail run is too short.
    dir_q.push_back(mk(ACT_ALLOC, 256 * 64, 0));
    dir_q.push_back(mk(ACT_CLEAR, 21'h1FFFFF, 20'hFFFFF));
    dir_q.push_back(mk(ACT_ALLOC, 256 * 64, 0));
    dir_q.push_back(mk(ACT_ALLOC, 1, 0));
    dir_q.push_back(mk(ACT_FREE, 21'h1FFFFF, 20'hFFFFF));
    dir_q.push_back(mk(ACT_FREE, 0, 255 * 64));
    dir_q.push_back(mk(ACT_FREE, 64, 255 * 64));
    dir_q.push_back(mk(ACT_ALLOC, 64, 0));
    dir_q.push_back(mk(ACT_FREE, 21'h1FFFFF, 100 * 64 + 5));
    dir_q.push_back(mk(ACT_ALLOC, 100 * 64 + 1, 0));
    dir_q.push_back(mk(action_t'(ACT_UNKNOWN), 5, 0));
    dir_q.push_back(mk(action_t'(ACT_UNKNOWN), 21'h1FFFFF, 20'hFFFFF));
    dir_q.push_back(mk(ACT_FREE, 1, 0));
    dir_q.push_back(mk(ACT_ALLOC, 128, 0));
    dir_q.push_back(mk(ACT_ALLOC, 1, 0));
    dir_q.push_back(mk(ACT_FREE, 21'h100000, 20'h80000));
    dir_q.push_back(mk(ACT_CLEAR, 0, 0));
    foreach (dir_q[i]) offer(dir_q[i]);

    run_phase(BB_MAX, CFG_DATA_W'(ACT_RESET), 110, 1'b1, -1);
    run_phase(13'd1, 13'd1, 50, 1'b0, -1);
    run_phase(13'd0, 13'd0, 30, 1'b0, -1);
    // Both registers above their range: clamped to 4096 bytes and 256 blocks.
    run_phase(13'h1FFF, 13'd511, 90, 1'b0, -1);
    run_phase(13'd24, 13'd37, 120, 1'b0, 60);
    run_phase(CFG_DATA_W'($urandom_range(1, 200)), CFG_DATA_W'($urandom_range(2, 256)),
              130, 1'b0, -1);
    run_phase(BB_RESET, CFG_DATA_W'(ACT_RESET), 120, 1'b0, -1);

    in_valid <= 1'b0;
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("contiguous_block_allocator_test passed");
    else
      $display("contiguous_block_allocator_test failed");
    $finish;
  end

endmodule
